// ===== hw/rtl/lufp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lufp_pkg
// Shared widths, register indexes, frame positions and reset values for the
// range-finder serial frame parser.
// ----------------------------------------------------------------------------
package lufp_pkg;

	localparam int BYTE_W     = 8;
	localparam int WORD_W     = 16;
	localparam int TEMP_W     = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int POS_W      = 4;
	localparam int PAYLOAD_N  = 6;
	localparam int PIDX_W     = 3;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_HEADER_VALUE   = 2'd0;
	localparam cfg_idx_t REG_DISTANCE_LIMIT = 2'd1;

	localparam logic [BYTE_W-1:0] HEADER_RESET = 8'd89;
	localparam logic [WORD_W-1:0] LIMIT_RESET  = 16'd300;

	typedef logic [POS_W-1:0] frame_pos_t;

	localparam frame_pos_t POS_HDR0    = 4'd0;
	localparam frame_pos_t POS_HDR1    = 4'd1;
	localparam frame_pos_t POS_PAY_LO  = 4'd2;
	localparam frame_pos_t POS_PAY_HI  = 4'd7;
	localparam frame_pos_t POS_CHKSUM  = 4'd8;

	// Temperature word is raw/8 with this offset removed.
	localparam logic [TEMP_W-1:0] TEMP_OFFSET = 14'd256;

endpackage
`default_nettype wire

// ===== hw/rtl/lidar_uart_frame_parser.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lidar_uart_frame_parser
// Recovers nine-byte range-finder frames from a stream of serial bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   beat. The block hunts for two header bytes equal to header_value, collects
//   six payload bytes, and on the checksum byte emits one result beat on the
//   output channel (out_valid/out_ready): checksum flag, clamped distance,
//   strength and temperature. All other bytes produce no result.
//   Throughput: one byte per cycle while no checksum byte is held. Latency:
//   the result is presented the cycle after the checksum byte is accepted;
//   state and result sit in registers behind one short compare/add/clamp path.
//   Stall: while a result waits, bytes keep being accepted, except a checksum
//   byte, which holds (in_ready low) until the waiting result is taken or is
//   taken in the same cycle.
//   Reset: position returns to header hunt, the running sum clears, the
//   output is empty, and the registers load header 89 and limit 300.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 header
//   value, 1 distance limit); other indexes are ignored. Write while idle.
// ----------------------------------------------------------------------------
module lidar_uart_frame_parser (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [lufp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [lufp_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire [lufp_pkg::BYTE_W-1:0]       rx_byte,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic                             checksum_ok,
	output logic [lufp_pkg::WORD_W-1:0]      distance_cm,
	output logic [lufp_pkg::WORD_W-1:0]      signal_strength,
	output logic signed [lufp_pkg::TEMP_W-1:0] temperature_c
);
	import lufp_pkg::*;

	logic [BYTE_W-1:0] header_q;
	logic [WORD_W-1:0] limit_q;
	frame_pos_t        pos_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] payload_q [PAYLOAD_N];

	logic              out_valid_q;
	logic              chk_ok_q;
	logic [WORD_W-1:0] dist_q;
	logic [WORD_W-1:0] str_q;
	logic [TEMP_W-1:0] temp_q;

	logic              accept;
	logic              hdr_match;
	logic [BYTE_W-1:0] sum_next;
	logic [PIDX_W-1:0] pidx;
	logic [WORD_W-1:0] dist_raw;
	logic [WORD_W-1:0] temp_raw;
	logic [WORD_W-1:0] dist_clamped;
	logic [TEMP_W-1:0] temp_next;

	// Hold a checksum byte while the previous result still waits.
	assign in_ready  = !(pos_q == POS_CHKSUM && out_valid_q && !out_ready);
	assign accept    = in_valid && in_ready;
	assign hdr_match = (rx_byte == header_q);
	assign sum_next  = sum_q + rx_byte;
	assign pidx      = PIDX_W'(pos_q - POS_PAY_LO);

	assign dist_raw     = {payload_q[1], payload_q[0]};
	assign temp_raw     = {payload_q[5], payload_q[4]};
	assign dist_clamped = (dist_raw > limit_q) ? limit_q : dist_raw;
	assign temp_next    = {1'b0, temp_raw[WORD_W-1:3]} - TEMP_OFFSET;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
			limit_q  <= LIMIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER_VALUE:   header_q <= cfg_wdata[BYTE_W-1:0];
				REG_DISTANCE_LIMIT: limit_q  <= cfg_wdata[WORD_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_HDR0;
			sum_q <= '0;
		end else if (accept) begin
			case (pos_q) inside
				POS_HDR0: begin
					if (hdr_match) begin
						sum_q <= rx_byte;
						pos_q <= POS_HDR1;
					end
				end
				POS_HDR1: begin
					if (hdr_match) begin
						sum_q <= sum_next;
						pos_q <= POS_PAY_LO;
					end else begin
						pos_q <= POS_HDR0;
					end
				end
				[POS_PAY_LO:POS_PAY_HI]: begin
					sum_q <= sum_next;
					pos_q <= pos_q + 4'd1;
				end
				POS_CHKSUM: begin
					sum_q <= '0;
					pos_q <= POS_HDR0;
				end
				default: pos_q <= POS_HDR0;
			endcase
		end
	end

	// Payload bytes carry no reset; every slot is written before it is read.
	always_ff @(posedge clk) begin
		if (accept && pos_q >= POS_PAY_LO && pos_q <= POS_PAY_HI) begin
			payload_q[pidx] <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && pos_q == POS_CHKSUM) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && pos_q == POS_CHKSUM) begin
			chk_ok_q <= (sum_q == rx_byte);
			dist_q   <= dist_clamped;
			str_q    <= {payload_q[3], payload_q[2]};
			temp_q   <= temp_next;
		end
	end

	assign out_valid       = out_valid_q;
	assign checksum_ok     = chk_ok_q;
	assign distance_cm     = dist_q;
	assign signal_strength = str_q;
	assign temperature_c   = $signed(temp_q);

endmodule
`default_nettype wire

// ===== hw/rtl/lufp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lufp_checker
// Port-level checks for the frame parser, bound to the top level.
// ----------------------------------------------------------------------------
module lufp_checker (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                in_valid,
	input wire                                in_ready,
	input wire                                out_valid,
	input wire                                out_ready,
	input wire                                checksum_ok,
	input wire [lufp_pkg::WORD_W-1:0]         distance_cm,
	input wire [lufp_pkg::WORD_W-1:0]         signal_strength,
	input wire signed [lufp_pkg::TEMP_W-1:0]  temperature_c
);
	import lufp_pkg::*;

	// A stalled result beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(checksum_ok) && $stable(distance_cm)
			&& $stable(signal_strength) && $stable(temperature_c))
		else $error("stalled result payload changed");

	// Input backpressure only comes from a waiting, stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("input held without a stalled result");

	// A new result only follows an accepted byte.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted byte");

	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_c >= -14'sd256)
		else $error("temperature below range");

endmodule

bind lidar_uart_frame_parser lufp_checker u_lufp_checker (.*);
`default_nettype wire

// ===== sim/lidar_uart_frame_parser_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_uart_frame_parser_test
// Self-checking bench for the range-finder serial frame parser. Feeds
// directed frames, then mostly well-formed random frames mixed with noise and
// broken headers, under several register settings and idle patterns. A
// scoreboard predicts each decoded frame and checks every output beat.
// ----------------------------------------------------------------------------
module lidar_uart_frame_parser_test;
	import lufp_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS  = 235;
	localparam int PHASE_N      = 6;

	// Indexes past the last register; the block must ignore writes to them.
	localparam cfg_idx_t REG_SPARE_2 = 2'd2;
	localparam cfg_idx_t REG_SPARE_3 = 2'd3;

	typedef struct {
		logic                      ok;
		logic [WORD_W-1:0]         distance;
		logic [WORD_W-1:0]         strength;
		logic signed [TEMP_W-1:0]  temp;
	} frame_result_t;

	class frame_scoreboard;
		logic [BYTE_W-1:0] hdr;
		logic [WORD_W-1:0] lim;
		frame_pos_t        pos;
		logic [BYTE_W-1:0] pay [PAYLOAD_N];
		logic [BYTE_W-1:0] sum;
		frame_result_t     pending [$];
		int                errors;

		function new();
			hdr    = HEADER_RESET;
			lim    = LIMIT_RESET;
			pos    = POS_HDR0;
			sum    = '0;
			errors = 0;
			foreach (pay[i]) pay[i] = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_HEADER_VALUE)
				hdr = data[BYTE_W-1:0];
			else if (idx == REG_DISTANCE_LIMIT)
				lim = data;
		endfunction

		function void note_byte(logic [BYTE_W-1:0] b);
			frame_result_t     res;
			logic [WORD_W-1:0] dw;
			logic [WORD_W-1:0] tw;
			int                t;
			if (pos == POS_HDR0) begin
				if (b == hdr) begin
					sum = b;
					pos = POS_HDR1;
				end
			end else if (pos == POS_HDR1) begin
				if (b == hdr) begin
					sum = sum + b;
					pos = POS_PAY_LO;
				end else begin
					pos = POS_HDR0;
				end
			end else if (pos >= POS_PAY_LO && pos <= POS_PAY_HI) begin
				pay[pos - POS_PAY_LO] = b;
				sum = sum + b;
				pos = pos + 1'b1;
			end else if (pos == POS_CHKSUM) begin
				dw           = {pay[1], pay[0]};
				tw           = {pay[5], pay[4]};
				t            = int'({3'b000, tw[15:3]}) - 256;
				res.ok       = (sum == b);
				res.distance = (dw > lim) ? lim : dw;
				res.strength = {pay[3], pay[2]};
				res.temp     = t[TEMP_W-1:0];
				pending.push_back(res);
				pos = POS_HDR0;
				sum = '0;
			end else begin
				pos = POS_HDR0;
			end
		endfunction

		function void check_result(frame_result_t got);
			frame_result_t want;
			if (pending.size() == 0) begin
				$error("result beat with no frame pending");
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.ok !== want.ok) begin
				$error("checksum_ok: expected %0d, got %0d", want.ok, got.ok);
				errors++;
			end
			if (got.distance !== want.distance) begin
				$error("distance_cm: expected %0d, got %0d", want.distance, got.distance);
				errors++;
			end
			if (got.strength !== want.strength) begin
				$error("signal_strength: expected %0d, got %0d", want.strength, got.strength);
				errors++;
			end
			if (got.temp !== want.temp) begin
				$error("temperature_c: expected %0d, got %0d", want.temp, got.temp);
				errors++;
			end
		endfunction
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	cfg_idx_t                  cfg_index = REG_HEADER_VALUE;
	logic [CFG_DATA_W-1:0]     cfg_wdata = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic [BYTE_W-1:0]         rx_byte   = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      checksum_ok;
	logic [WORD_W-1:0]         distance_cm;
	logic [WORD_W-1:0]         signal_strength;
	logic signed [TEMP_W-1:0]  temperature_c;

	frame_scoreboard sb = new();
	int              send_idle_pct = 9;
	int              recv_idle_pct = 61;
	int              items_sent    = 0;
	int              quiet_cycles  = 0;

	lidar_uart_frame_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.checksum_ok     (checksum_ok),
		.distance_cm     (distance_cm),
		.signal_strength (signal_strength),
		.temperature_c   (temperature_c)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Score accepted beats and watch for a hung handshake.
	always @(posedge clk) begin
		frame_result_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.ok       = checksum_ok;
				got.distance = distance_cm;
				got.strength = signal_strength;
				got.temp     = temperature_c;
				sb.check_result(got);
			end
			if (in_valid && in_ready)
				sb.note_byte(rx_byte);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	// Hold the sender until every pending frame result has been taken.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.set_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_frame(input logic [WORD_W-1:0] distance, input logic [WORD_W-1:0] strength,
			input logic [WORD_W-1:0] traw, input bit good);
		logic [BYTE_W-1:0] body [PAYLOAD_N];
		logic [BYTE_W-1:0] chk;
		logic [BYTE_W-1:0] h;
		h       = sb.hdr;
		body[0] = distance[7:0];
		body[1] = distance[15:8];
		body[2] = strength[7:0];
		body[3] = strength[15:8];
		body[4] = traw[7:0];
		body[5] = traw[15:8];
		chk     = h + h;
		foreach (body[i]) chk = chk + body[i];
		if (!good)
			chk = chk ^ 8'($urandom_range(255, 1));
		send_byte(h);
		send_byte(h);
		foreach (body[i]) send_byte(body[i]);
		send_byte(chk);
	endtask

	function automatic logic [WORD_W-1:0] pick_word(input logic [WORD_W-1:0] near);
		int v;
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2, 3: begin
				v = int'(near) + $urandom_range(4) - 2;
				if (v < 0) v = 0;
				if (v > 65535) v = 65535;
				return v[WORD_W-1:0];
			end
			default: return WORD_W'($urandom);
		endcase
	endfunction

	task automatic send_random_burst();
		int                k;
		int                n;
		logic [BYTE_W-1:0] b;
		k = $urandom_range(99);
		if (k < 80) begin
			send_frame(pick_word(sb.lim), pick_word(WORD_W'($urandom)),
				pick_word(WORD_W'($urandom)), $urandom_range(99) < 85);
		end else if (k < 90) begin
			n = $urandom_range(4, 1);
			repeat (n) begin
				b = ($urandom_range(3) == 0) ? sb.hdr : BYTE_W'($urandom);
				send_byte(b);
			end
		end else begin
			// Broken header: the second byte misses.
			send_byte(sb.hdr);
			send_byte(sb.hdr ^ BYTE_W'($urandom_range(255, 1)));
		end
	endtask

	task automatic configure(input int ph);
		case (ph)
			1: begin
				write_reg(REG_HEADER_VALUE, {8'($urandom), 8'h00});
				write_reg(REG_DISTANCE_LIMIT, 16'h0000);
			end
			2: begin
				write_reg(REG_HEADER_VALUE, {8'($urandom), 8'hff});
				write_reg(REG_DISTANCE_LIMIT, 16'hffff);
			end
			3: begin
				write_reg(REG_HEADER_VALUE, CFG_DATA_W'($urandom));
				write_reg(REG_DISTANCE_LIMIT, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
				write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
			end
			4: begin
				write_reg(REG_HEADER_VALUE, CFG_DATA_W'($urandom));
				write_reg(REG_DISTANCE_LIMIT, CFG_DATA_W'($urandom_range(511)));
			end
			5: begin
				write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
				write_reg(REG_HEADER_VALUE, {8'h00, HEADER_RESET});
				write_reg(REG_DISTANCE_LIMIT, LIMIT_RESET);
			end
			default: ;
		endcase
	endtask

	initial begin
		int  target;
		bit  paused;
		paused = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: all-ones frame, all-zeros frame with bad checksum,
		// then a header whose second byte misses, then a stray byte.
		send_frame(16'hffff, 16'hffff, 16'hffff, 1'b1);
		send_frame(16'h0000, 16'h0000, 16'h0000, 1'b0);
		send_byte(sb.hdr);
		send_byte(sb.hdr ^ 8'h01);
		send_byte(8'h00);

		for (int ph = 0; ph < PHASE_N; ph++) begin
			if (ph < 2) begin
				send_idle_pct = 9;
				recv_idle_pct = 61;
			end else if (ph < 4) begin
				send_idle_pct = 61;
				recv_idle_pct = 9;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			drain();
			configure(ph);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if (ph == 3 && !paused && items_sent >= target - PHASE_ITEMS / 2) begin
					drain();
					paused = 1'b1;
				end
				send_random_burst();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
